/* rtl/ddcw_pkg.sv */
package ddcw_pkg;

   localparam int unsigned COUNT_W = 16;
   localparam int unsigned DUTY_W  = 8;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CSR_INDEX_W = 2;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEARTBEAT       = 2'd2;

   localparam logic [COUNT_W-1:0] COMMAND_TIMEOUT_RESET = 16'd750;
   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET        = 16'd100;
   localparam logic [COUNT_W-1:0] HEARTBEAT_RESET       = 16'd500;
   localparam logic [DUTY_W-1:0]  SPEED_DUTY_RESET      = 8'd102;
   localparam logic [COUNT_W-1:0] COUNT_MAX             = 16'hFFFF;

   // item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // motor direction codes
   localparam logic [1:0] DIR_OFF     = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   // command characters, lower case; upper case folds onto them
   localparam logic [BYTE_W-1:0] CHAR_CASE_BIT = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_F     = 8'h66;
   localparam logic [BYTE_W-1:0] CHAR_B     = 8'h62;
   localparam logic [BYTE_W-1:0] CHAR_L     = 8'h6C;
   localparam logic [BYTE_W-1:0] CHAR_R     = 8'h72;
   localparam logic [BYTE_W-1:0] CHAR_S     = 8'h73;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      MODE_STOP    = 3'd0,
      MODE_FORWARD = 3'd1,
      MODE_BACKWARD = 3'd2,
      MODE_PIVOT_LEFT = 3'd3,
      MODE_PIVOT_RIGHT = 3'd4
   } mode_type;

   typedef struct packed {
      logic              command;
      logic [BYTE_W-1:0] rx_byte;
      logic              link_pin;
   } req_type;

   typedef struct packed {
      logic [1:0]        left_dir;
      logic [1:0]        right_dir;
      logic [DUTY_W-1:0] motor_pwm;
      logic              moving;
      logic              link_up;
      logic              led_on;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] command_timeout_ticks;
      logic [COUNT_W-1:0] debounce_ticks;
      logic [COUNT_W-1:0] heartbeat_ticks;
   } cfg_type;

   function automatic logic [DUTY_W-1:0] duty_lookup(input logic [3:0] digit);
      logic [DUTY_W-1:0] duty;
      case (digit)
         4'd0: duty = 8'd0;
         4'd1: duty = 8'd28;
         4'd2: duty = 8'd56;
         4'd3: duty = 8'd84;
         4'd4: duty = 8'd112;
         4'd5: duty = 8'd140;
         4'd6: duty = 8'd168;
         4'd7: duty = 8'd196;
         4'd8: duty = 8'd224;
         4'd9: duty = 8'd255;
         default: duty = 8'd0;
      endcase
      return duty;
   endfunction

endpackage

/* rtl/ddcw_csr.sv */
module ddcw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ddcw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ddcw_pkg::COUNT_W-1:0]        csr_data,
   output ddcw_pkg::cfg_type                   cfg
);

   ddcw_pkg::cfg_type cfg_ff;
   ddcw_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ddcw_pkg::CSR_COMMAND_TIMEOUT: cfg_in.command_timeout_ticks = csr_data;
            ddcw_pkg::CSR_DEBOUNCE:        cfg_in.debounce_ticks        = csr_data;
            ddcw_pkg::CSR_HEARTBEAT:       cfg_in.heartbeat_ticks       = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_timeout_ticks <= ddcw_pkg::COMMAND_TIMEOUT_RESET;
         cfg_ff.debounce_ticks        <= ddcw_pkg::DEBOUNCE_RESET;
         cfg_ff.heartbeat_ticks       <= ddcw_pkg::HEARTBEAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/ddcw_core.sv */
module ddcw_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  ddcw_pkg::req_type  item,
   input  ddcw_pkg::cfg_type  cfg,
   output ddcw_pkg::rsp_type  result
);

   ddcw_pkg::mode_type           mode_ff, mode_in;
   logic [ddcw_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   logic [ddcw_pkg::COUNT_W-1:0] since_command_ff, since_command_in;
   logic [ddcw_pkg::COUNT_W-1:0] since_link_ff, since_link_in;
   logic [ddcw_pkg::COUNT_W-1:0] since_toggle_ff, since_toggle_in;
   logic                         last_raw_ff, last_raw_in;
   logic                         link_ff, link_in;
   logic                         led_ff, led_in;

   logic [ddcw_pkg::BYTE_W-1:0]  folded;
   logic [ddcw_pkg::COUNT_W-1:0] interval;
   logic                         moving;

   function automatic logic [ddcw_pkg::COUNT_W-1:0] sat_inc(
      input logic [ddcw_pkg::COUNT_W-1:0] v);
      return (v == ddcw_pkg::COUNT_MAX) ? v : v + 1'b1;
   endfunction

   assign folded = item.rx_byte | ddcw_pkg::CHAR_CASE_BIT;

   always_comb begin
      mode_in          = mode_ff;
      duty_in          = duty_ff;
      since_command_in = since_command_ff;
      since_link_in    = since_link_ff;
      since_toggle_in  = since_toggle_ff;
      last_raw_in      = last_raw_ff;
      link_in          = link_ff;
      led_in           = led_ff;
      interval         = cfg.heartbeat_ticks;

      if (item.command == ddcw_pkg::KIND_BYTE) begin
         since_command_in = '0;
         if (item.rx_byte >= ddcw_pkg::CHAR_ZERO && item.rx_byte <= ddcw_pkg::CHAR_NINE) begin
            duty_in = ddcw_pkg::duty_lookup(item.rx_byte[3:0]);
         end else begin
            case (folded)
               ddcw_pkg::CHAR_F: mode_in = ddcw_pkg::MODE_FORWARD;
               ddcw_pkg::CHAR_B: mode_in = ddcw_pkg::MODE_BACKWARD;
               ddcw_pkg::CHAR_L: mode_in = ddcw_pkg::MODE_PIVOT_LEFT;
               ddcw_pkg::CHAR_R: mode_in = ddcw_pkg::MODE_PIVOT_RIGHT;
               ddcw_pkg::CHAR_S: mode_in = ddcw_pkg::MODE_STOP;
               default: ;
            endcase
         end
      end else begin
         since_command_in = sat_inc(since_command_ff);
         since_link_in    = sat_inc(since_link_ff);
         since_toggle_in  = sat_inc(since_toggle_ff);

         if (item.link_pin != last_raw_ff) begin
            last_raw_in   = item.link_pin;
            since_link_in = '0;
         end
         if (since_link_in >= cfg.debounce_ticks && item.link_pin != link_ff) begin
            link_in = item.link_pin;
            if (!item.link_pin) begin
               mode_in = ddcw_pkg::MODE_STOP;
            end
         end
         if (mode_in != ddcw_pkg::MODE_STOP &&
             since_command_in > cfg.command_timeout_ticks) begin
            mode_in = ddcw_pkg::MODE_STOP;
         end

         // quarter interval while driving
         if (mode_in != ddcw_pkg::MODE_STOP) begin
            interval = cfg.heartbeat_ticks >> 2;
         end
         if (since_toggle_in >= interval) begin
            since_toggle_in = '0;
            led_in          = ~led_ff;
         end
      end
   end

   assign moving = (mode_in != ddcw_pkg::MODE_STOP);

   always_comb begin
      case (mode_in)
         ddcw_pkg::MODE_FORWARD: begin
            result.left_dir  = ddcw_pkg::DIR_FORWARD;
            result.right_dir = ddcw_pkg::DIR_FORWARD;
         end
         ddcw_pkg::MODE_BACKWARD: begin
            result.left_dir  = ddcw_pkg::DIR_REVERSE;
            result.right_dir = ddcw_pkg::DIR_REVERSE;
         end
         ddcw_pkg::MODE_PIVOT_LEFT: begin
            result.left_dir  = ddcw_pkg::DIR_REVERSE;
            result.right_dir = ddcw_pkg::DIR_FORWARD;
         end
         ddcw_pkg::MODE_PIVOT_RIGHT: begin
            result.left_dir  = ddcw_pkg::DIR_FORWARD;
            result.right_dir = ddcw_pkg::DIR_REVERSE;
         end
         default: begin
            result.left_dir  = ddcw_pkg::DIR_OFF;
            result.right_dir = ddcw_pkg::DIR_OFF;
         end
      endcase
      result.motor_pwm = moving ? duty_in : '0;
      result.moving    = moving;
      result.link_up   = link_in;
      result.led_on    = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= ddcw_pkg::MODE_STOP;
         duty_ff          <= ddcw_pkg::SPEED_DUTY_RESET;
         since_command_ff <= '0;
         since_link_ff    <= '0;
         since_toggle_ff  <= '0;
         last_raw_ff      <= 1'b0;
         link_ff          <= 1'b0;
         led_ff           <= 1'b0;
      end else if (enable) begin
         mode_ff          <= mode_in;
         duty_ff          <= duty_in;
         since_command_ff <= since_command_in;
         since_link_ff    <= since_link_in;
         since_toggle_ff  <= since_toggle_in;
         last_raw_ff      <= last_raw_in;
         link_ff          <= link_in;
         led_ff           <= led_in;
      end
   end

endmodule

/* rtl/diff_drive_command_watchdog_unit.sv */
// Tank drive controller with command watchdog, link debouncer and heartbeat LED.
// Items are either a received command byte or a one millisecond tick carrying
// the raw link pin; every item yields exactly one result item showing motor
// directions, pwm duty, moving, debounced link and LED state after that item.
// One item per clock is sustained while rsp_stall is low: an item is held in
// the input register, the state update and result decode run in one pass of
// logic, and the result is held in the output register until taken. rsp_valid
// rises when the item moves from the input register into the output register,
// which waits while a stalled result still fills it. Back pressure on rsp_stall
// reaches req_stall only once both the input and the output register hold an
// item. Registers are written through the csr port (always ready); the user must
// write them only while no item is in flight, not enforced by the block: 0 command
// timeout, 1 debounce length, 2 heartbeat interval; other indexes are ignored.
module diff_drive_command_watchdog_unit (
   input  logic                             clock,
   input  logic                             reset,
   // item input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ddcw_pkg::req_type                req_data,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ddcw_pkg::rsp_type                rsp_data,
   // register write port
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ddcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ddcw_pkg::COUNT_W-1:0]     csr_data
);

   ddcw_pkg::cfg_type cfg;
   ddcw_pkg::rsp_type result;

   // input register
   logic              in_valid_ff, in_valid_in;
   ddcw_pkg::req_type in_data_ff;

   // output register
   logic              out_valid_ff, out_valid_in;
   ddcw_pkg::rsp_type out_data_ff;

   logic accept;
   logic advance;

   // the held item moves on when the output register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   ddcw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // state commits only when the item moves into the output register
   ddcw_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* rtl/ddcw_checker.sv */
module ddcw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input ddcw_pkg::rsp_type                rsp_data
);

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // input side stalls only behind a result that is itself stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back pressure");

   // a stopped drive shows no direction and no duty
   a_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.moving |->
         rsp_data.motor_pwm == '0 && rsp_data.left_dir == ddcw_pkg::DIR_OFF &&
         rsp_data.right_dir == ddcw_pkg::DIR_OFF)
      else $error("motors driven while stopped");

   // a moving drive turns both motors
   a_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.moving |->
         rsp_data.left_dir != ddcw_pkg::DIR_OFF && rsp_data.right_dir != ddcw_pkg::DIR_OFF)
      else $error("moving with a motor off");

endmodule

bind diff_drive_command_watchdog_unit ddcw_checker u_ddcw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* test/testbench.sv */
`timescale 1ns / 1ps

// tracks what the drive controller should report after every item
class drive_scoreboard;
   logic [ddcw_pkg::COUNT_W-1:0] timeout_len;
   logic [ddcw_pkg::COUNT_W-1:0] debounce_len;
   logic [ddcw_pkg::COUNT_W-1:0] heartbeat_len;

   ddcw_pkg::mode_type           mode;
   logic [ddcw_pkg::DUTY_W-1:0]  duty;
   logic [ddcw_pkg::COUNT_W-1:0] since_byte;
   logic [ddcw_pkg::COUNT_W-1:0] since_pin_edge;
   logic [ddcw_pkg::COUNT_W-1:0] since_blink;
   logic                         raw_pin;
   logic                         link;
   logic                         led;

   ddcw_pkg::rsp_type            expected_q[$];
   int                           errors;

   function new();
      timeout_len    = ddcw_pkg::COMMAND_TIMEOUT_RESET;
      debounce_len   = ddcw_pkg::DEBOUNCE_RESET;
      heartbeat_len  = ddcw_pkg::HEARTBEAT_RESET;
      mode           = ddcw_pkg::MODE_STOP;
      duty           = ddcw_pkg::SPEED_DUTY_RESET;
      since_byte     = '0;
      since_pin_edge = '0;
      since_blink    = '0;
      raw_pin        = 1'b0;
      link           = 1'b0;
      led            = 1'b0;
      errors         = 0;
   endfunction

   function void note_config(logic [ddcw_pkg::CSR_INDEX_W-1:0] index,
                             logic [ddcw_pkg::COUNT_W-1:0] value);
      case (index)
         ddcw_pkg::CSR_COMMAND_TIMEOUT: timeout_len = value;
         ddcw_pkg::CSR_DEBOUNCE:        debounce_len = value;
         ddcw_pkg::CSR_HEARTBEAT:       heartbeat_len = value;
         default: ;
      endcase
   endfunction

   function logic [ddcw_pkg::COUNT_W-1:0] bump(logic [ddcw_pkg::COUNT_W-1:0] count);
      return (count == ddcw_pkg::COUNT_MAX) ? count : count + 1'b1;
   endfunction

   function void note_request(ddcw_pkg::req_type item);
      logic [3:0]                   digit;
      logic [ddcw_pkg::COUNT_W-1:0] interval;
      ddcw_pkg::rsp_type            result;
      if (item.command == ddcw_pkg::KIND_BYTE) begin
         since_byte = '0;
         if (item.rx_byte >= ddcw_pkg::CHAR_ZERO && item.rx_byte <= ddcw_pkg::CHAR_NINE) begin
            digit = 4'(item.rx_byte - ddcw_pkg::CHAR_ZERO);
            // steps of 28, top digit clamped to full scale
            duty = (digit == 4'd9) ? 8'd255 : 8'(digit * 28);
         end else begin
            case (item.rx_byte | ddcw_pkg::CHAR_CASE_BIT)
               ddcw_pkg::CHAR_F: mode = ddcw_pkg::MODE_FORWARD;
               ddcw_pkg::CHAR_B: mode = ddcw_pkg::MODE_BACKWARD;
               ddcw_pkg::CHAR_L: mode = ddcw_pkg::MODE_PIVOT_LEFT;
               ddcw_pkg::CHAR_R: mode = ddcw_pkg::MODE_PIVOT_RIGHT;
               ddcw_pkg::CHAR_S: mode = ddcw_pkg::MODE_STOP;
               default: ;
            endcase
         end
      end else begin
         since_byte     = bump(since_byte);
         since_pin_edge = bump(since_pin_edge);
         since_blink    = bump(since_blink);
         if (item.link_pin != raw_pin) begin
            raw_pin        = item.link_pin;
            since_pin_edge = '0;
         end
         if (since_pin_edge >= debounce_len && item.link_pin != link) begin
            link = item.link_pin;
            if (!link) mode = ddcw_pkg::MODE_STOP;
         end
         if (mode != ddcw_pkg::MODE_STOP && since_byte > timeout_len) begin
            mode = ddcw_pkg::MODE_STOP;
         end
         interval = (mode != ddcw_pkg::MODE_STOP) ? (heartbeat_len >> 2) : heartbeat_len;
         if (since_blink >= interval) begin
            since_blink = '0;
            led         = ~led;
         end
      end

      case (mode)
         ddcw_pkg::MODE_FORWARD: begin
            result.left_dir  = ddcw_pkg::DIR_FORWARD;
            result.right_dir = ddcw_pkg::DIR_FORWARD;
         end
         ddcw_pkg::MODE_BACKWARD: begin
            result.left_dir  = ddcw_pkg::DIR_REVERSE;
            result.right_dir = ddcw_pkg::DIR_REVERSE;
         end
         ddcw_pkg::MODE_PIVOT_LEFT: begin
            result.left_dir  = ddcw_pkg::DIR_REVERSE;
            result.right_dir = ddcw_pkg::DIR_FORWARD;
         end
         ddcw_pkg::MODE_PIVOT_RIGHT: begin
            result.left_dir  = ddcw_pkg::DIR_FORWARD;
            result.right_dir = ddcw_pkg::DIR_REVERSE;
         end
         default: begin
            result.left_dir  = ddcw_pkg::DIR_OFF;
            result.right_dir = ddcw_pkg::DIR_OFF;
         end
      endcase
      result.moving    = (mode != ddcw_pkg::MODE_STOP);
      result.motor_pwm = result.moving ? duty : '0;
      result.link_up   = link;
      result.led_on    = led;
      expected_q.push_back(result);
   endfunction

   function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         errors++;
      end
   endfunction

   function void check_result(ddcw_pkg::rsp_type got);
      ddcw_pkg::rsp_type want;
      if (expected_q.size() == 0) begin
         $error("result item with nothing expected");
         errors++;
         return;
      end
      want = expected_q.pop_front();
      compare_field("left_dir", want.left_dir, got.left_dir);
      compare_field("right_dir", want.right_dir, got.right_dir);
      compare_field("motor_pwm", want.motor_pwm, got.motor_pwm);
      compare_field("moving", want.moving, got.moving);
      compare_field("link_up", want.link_up, got.link_up);
      compare_field("led_on", want.led_on, got.led_on);
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module testbench;

   // index with no register behind it, writes must be dropped
   localparam logic [ddcw_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int RESET_CYCLES    = 11;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int QUIET_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 10;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;

   logic                             req_valid = 1'b0;
   logic                             req_stall;
   ddcw_pkg::req_type                req_data = '0;

   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   ddcw_pkg::rsp_type                rsp_data;

   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ddcw_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ddcw_pkg::COUNT_W-1:0]     csr_data = '0;

   drive_scoreboard                  board;

   // idling knobs, percent of cycles
   int                               send_idle_pct = 0;
   int                               stall_pct = 0;

   // long receiver hold-off, asked for by the stimulus and timed by the receiver
   int                               hold_asked = 0;
   int                               hold_granted = 0;
   int                               hold_left = 0;

   // current level of the simulated link pin
   logic                             held_pin = 1'b0;

   int                               quiet_cycles = 0;

   diff_drive_command_watchdog_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // receiver side: random stalls, plus one long hold-off when asked
   always @(negedge clock) begin
      if (hold_asked != hold_granted) begin
         hold_granted = hold_asked;
         hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // every accepted result goes against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // give up when no channel has moved anything for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic ddcw_pkg::req_type byte_item(logic [ddcw_pkg::BYTE_W-1:0] value);
      ddcw_pkg::req_type item;
      item.command  = ddcw_pkg::KIND_BYTE;
      item.rx_byte  = value;
      item.link_pin = 1'($urandom_range(1));  // don't care for bytes
      return item;
   endfunction

   function automatic ddcw_pkg::req_type tick_item(logic pin);
      ddcw_pkg::req_type item;
      item.command  = ddcw_pkg::KIND_TICK;
      item.rx_byte  = 8'($urandom_range(255));  // don't care for ticks
      item.link_pin = pin;
      return item;
   endfunction

   // mostly ticks with a steady pin and the odd glitch, bytes mostly real commands
   function automatic ddcw_pkg::req_type random_item();
      logic [ddcw_pkg::BYTE_W-1:0] letter;
      if ($urandom_range(99) < 62) begin
         if ($urandom_range(99) < 6) held_pin = ~held_pin;
         return tick_item(held_pin);
      end
      case ($urandom_range(3))
         0, 1: begin
            case ($urandom_range(4))
               0: letter = ddcw_pkg::CHAR_F;
               1: letter = ddcw_pkg::CHAR_B;
               2: letter = ddcw_pkg::CHAR_L;
               3: letter = ddcw_pkg::CHAR_R;
               default: letter = ddcw_pkg::CHAR_S;
            endcase
            if ($urandom_range(1)) letter = letter & ~ddcw_pkg::CHAR_CASE_BIT;
            return byte_item(letter);
         end
         2: return byte_item(ddcw_pkg::CHAR_ZERO + 8'($urandom_range(9)));
         default: return byte_item(8'($urandom_range(255)));
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input ddcw_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(item);
      @(negedge clock);
   endtask

   // leaves csr_valid high, the caller drops it after the last write
   task automatic write_register(input logic [ddcw_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [ddcw_pkg::COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.note_config(index, value);
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [ddcw_pkg::COUNT_W-1:0] timeout_val,
                                input logic [ddcw_pkg::COUNT_W-1:0] debounce_val,
                                input logic [ddcw_pkg::COUNT_W-1:0] heartbeat_val,
                                input bit stray);
      write_register(ddcw_pkg::CSR_COMMAND_TIMEOUT, timeout_val);
      write_register(ddcw_pkg::CSR_DEBOUNCE, debounce_val);
      write_register(ddcw_pkg::CSR_HEARTBEAT, heartbeat_val);
      if (stray) write_register(CSR_UNUSED, 16'($urandom_range(65535)));
      csr_valid <= 1'b0;
   endtask

   // short values so the watchdog, debouncer and heartbeat all fire often
   task automatic load_short_settings();
      load_settings(16'($urandom_range(12, 1)), 16'($urandom_range(8, 1)),
                    16'($urandom_range(20, 4)), 1'b0);
   endtask

   // stop offering and let every predicted result drain out
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic run_random(input int count, input int send_pct, input int stall_in);
      send_idle_pct = send_pct;
      stall_pct     = stall_in;
      repeat (count) send_item(random_item());
   endtask

   task automatic run_directed();
      send_item(tick_item(1'b0));
      // every drive letter in both cases
      send_item(byte_item(ddcw_pkg::CHAR_F & ~ddcw_pkg::CHAR_CASE_BIT));
      send_item(byte_item(ddcw_pkg::CHAR_NINE));               // full speed applies at once
      send_item(byte_item(ddcw_pkg::CHAR_B));
      send_item(byte_item(ddcw_pkg::CHAR_L & ~ddcw_pkg::CHAR_CASE_BIT));
      send_item(byte_item(ddcw_pkg::CHAR_R));
      send_item(byte_item(ddcw_pkg::CHAR_L));
      send_item(byte_item(ddcw_pkg::CHAR_B & ~ddcw_pkg::CHAR_CASE_BIT));
      send_item(byte_item(ddcw_pkg::CHAR_R & ~ddcw_pkg::CHAR_CASE_BIT));
      send_item(byte_item(ddcw_pkg::CHAR_F));
      send_item(byte_item(ddcw_pkg::CHAR_ZERO));               // zero duty while still moving
      send_item(byte_item(ddcw_pkg::CHAR_S & ~ddcw_pkg::CHAR_CASE_BIT));
      send_item(byte_item(ddcw_pkg::CHAR_ZERO + 8'd5));        // digit while stopped only stores
      send_item(byte_item(ddcw_pkg::CHAR_F));
      send_item(byte_item(ddcw_pkg::CHAR_S));
      // unknown bytes, including ones that alias a digit or letter if case-folded
      send_item(byte_item(8'h00));
      send_item(byte_item(8'hFF));
      send_item(byte_item(ddcw_pkg::CHAR_ZERO & ~ddcw_pkg::CHAR_CASE_BIT));
      send_item(byte_item(ddcw_pkg::CHAR_F | 8'h80));
      // tick whose ignored byte field holds a drive letter
      send_item('{command: ddcw_pkg::KIND_TICK, rx_byte: ddcw_pkg::CHAR_F, link_pin: 1'b1});
      send_item(tick_item(1'b1));
      send_item(tick_item(1'b0));
   endtask

   initial begin
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values of the registers first
      run_directed();
      settle();

      load_short_settings();
      run_random(130, 0, 0);
      settle();

      // lowest legal values
      load_settings(16'd1, 16'd1, 16'd4, 1'b0);
      run_random(130, 57, 0);
      settle();

      // receiver holds off while the sender keeps pushing, block backs up
      load_short_settings();
      hold_asked++;
      run_random(130, 0, 57);
      settle();

      // zero timeout, instant debounce, LED toggling every tick
      load_settings(16'd0, 16'd0, 16'd0, 1'b0);
      run_random(130, 20, 20);
      settle();

      // full-scale values with a stray write to the unused index
      load_settings(ddcw_pkg::COUNT_MAX, ddcw_pkg::COUNT_MAX, ddcw_pkg::COUNT_MAX, 1'b1);
      send_idle_pct = 0;
      stall_pct     = 0;
      send_item(byte_item(ddcw_pkg::CHAR_F));
      run_random(40, 0, 0);
      settle();

      load_short_settings();
      run_random(130, 57, 0);
      settle();

      load_short_settings();
      run_random(130, 0, 57);
      settle();

      load_short_settings();
      run_random(130, 20, 20);
      settle();

      load_short_settings();
      run_random(100, 0, 0);
      settle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/ddcw_pkg.sv
rtl/ddcw_csr.sv
rtl/ddcw_core.sv
rtl/diff_drive_command_watchdog_unit.sv
rtl/ddcw_checker.sv
test/testbench.sv
